// File: src/tmuf_pkg.sv
package tmuf_pkg;

  // Window geometry
  localparam int WINDOW_SIZE   = 10;
  localparam int TRIM_EACH_END = 2;
  localparam int MID_COUNT     = WINDOW_SIZE - 2 * TRIM_EACH_END;
  localparam bit MID_OK        = (MID_COUNT > 0);
  localparam int MID_N         = MID_OK ? MID_COUNT : 1;

  localparam int CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam int IDX_W = $clog2(WINDOW_SIZE);

  // Field widths
  localparam int RAW_W    = 12;
  localparam int SCALED_W = 11;
  localparam int OUT_W    = 17;

  // Input scaling: v = floor(raw * SCALE_MUL / SCALE_DIV)
  localparam int SCALE_MUL   = 1200;
  localparam int SCALE_DIV   = 2605;
  localparam int SCALED_MAX  = ((2 ** RAW_W - 1) * SCALE_MUL) / SCALE_DIV;
  localparam int X_W         = $clog2((2 ** RAW_W - 1) * SCALE_MUL + 1);
  localparam int SCALE_SHIFT = 32;
  localparam logic [63:0] SCALE_RECIP = (64'd1 << SCALE_SHIFT) / SCALE_DIV;
  localparam int RECIP1_W    = $clog2(SCALE_RECIP + 1);
  localparam int PROD1_W     = X_W + RECIP1_W;

  // Reading: floor(2048 * S / (100 * M)) - 2048
  localparam int READ_OFFSET = 8 * 256;
  localparam int U_SHIFT     = $clog2(READ_OFFSET);
  localparam int SUM_W       = $clog2(MID_N * SCALED_MAX + 1);
  localparam int U_W         = SUM_W + U_SHIFT;
  localparam int DIV_D       = 100 * MID_N;
  localparam int DIV_P       = U_W;
  localparam logic [63:0] DIV_RECIP = (64'd1 << DIV_P) / DIV_D;
  localparam int RECIP2_W    = $clog2(DIV_RECIP + 1);
  localparam int PROD2_W     = U_W + RECIP2_W;
  localparam int QD_W        = $clog2((READ_OFFSET * SCALED_MAX) / 100 + 1);
  localparam int RES_W       = QD_W + 2;
  localparam int OUT_MAX     = 2 ** (OUT_W - 1) - 1;

  typedef struct packed {
    logic load;
    logic est;
    logic fix;
    logic ins;
    logic sum_init;
    logic sum_add;
    logic div1;
    logic div2;
  } tmuf_cmd_t;

  typedef struct packed {
    logic last_sample;
    logic sum_last;
  } tmuf_stat_t;

endpackage

// File: src/trimmed_mean_uv_sensor_filter.sv
// Channel  | Ports                         | Direction | Transfer
// ---------+-------------------------------+-----------+----------------------------------
// sample   | start, raw_sample_i [11:0]    | in        | edge with start high, busy low
// reading  | valid_o, uv_average_o [16:0]  | out       | the one cycle valid_o is high
//
// A sample keeps busy high through the reciprocal multiply, correction and
// sorted insert, so the next sample is taken only after the last is inserted.
// The tenth sample adds an accumulate over the six middle entries and a divide
// (estimate, then correction): busy stays high through it and the reading
// shows in the first cycle after busy falls. Reset empties the window; the
// receiver cannot stall, so each reading is shown for exactly one cycle.
module trimmed_mean_uv_sensor_filter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic [tmuf_pkg::RAW_W-1:0]        raw_sample_i,
  output logic                              busy,
  output logic                              valid_o,
  output logic signed [tmuf_pkg::OUT_W-1:0] uv_average_o
);
  import tmuf_pkg::*;

  // Commands from the sequencer, status back from the datapath
  tmuf_cmd_t  cmd;
  tmuf_stat_t stat;

  // Sequence each sample: load, scale estimate, fix, insert; on a full window
  // accumulate the middle entries and divide.
  tmuf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Hold the sorted window, the sum and the divider; register the reading.
  tmuf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .raw_sample_i (raw_sample_i),
    .stat_o       (stat),
    .valid_o      (valid_o),
    .uv_average_o (uv_average_o)
  );

endmodule

// File: src/tmuf_ctrl.sv
module tmuf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  tmuf_pkg::tmuf_stat_t stat_i,
  output tmuf_pkg::tmuf_cmd_t  cmd_o,
  output logic               busy_o
);
  import tmuf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EST  = 3'd1;
  localparam logic [2:0] ST_FIX  = 3'd2;
  localparam logic [2:0] ST_INS  = 3'd3;
  localparam logic [2:0] ST_SUM  = 3'd4;
  localparam logic [2:0] ST_DIV1 = 3'd5;
  localparam logic [2:0] ST_DIV2 = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EST;
        end
      end
      ST_EST: begin
        cmd_o.est = 1'b1;
        state_d   = ST_FIX;
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_INS;
      end
      ST_INS: begin
        cmd_o.ins = 1'b1;
        if (stat_i.last_sample) begin
          cmd_o.sum_init = 1'b1;
          state_d        = MID_OK ? ST_SUM : ST_DIV1;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        cmd_o.sum_add = 1'b1;
        if (stat_i.sum_last) begin
          state_d = ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd_o.div1 = 1'b1;
        state_d    = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.div2 = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

// File: src/tmuf_datapath.sv
module tmuf_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tmuf_pkg::tmuf_cmd_t               cmd_i,
  input  logic [tmuf_pkg::RAW_W-1:0]        raw_sample_i,
  output tmuf_pkg::tmuf_stat_t              stat_o,
  output logic                              valid_o,
  output logic signed [tmuf_pkg::OUT_W-1:0] uv_average_o
);
  import tmuf_pkg::*;

  logic [X_W-1:0]       x_q;
  logic [SCALED_W-1:0]  qe_q;
  logic [SCALED_W-1:0]  v_q;
  logic [SCALED_W-1:0]  win_q [WINDOW_SIZE];
  logic [SCALED_W-1:0]  win_d [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] gt;
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     idx_q;
  logic [SUM_W-1:0]     acc_q;
  logic [QD_W-1:0]      qd_q;
  logic                 valid_q;
  logic signed [OUT_W-1:0] res_q;

  logic [PROD1_W-1:0]   prod1;
  logic [X_W-1:0]       back1;
  logic [X_W-1:0]       rem1;
  logic [SCALED_W-1:0]  v_d;
  logic [U_W-1:0]       u;
  logic [PROD2_W-1:0]   prod2;
  logic [U_W-1:0]       back2;
  logic [U_W-1:0]       rem2;
  logic [QD_W:0]        qf;
  logic signed [RES_W-1:0] res_full;
  logic signed [OUT_W-1:0] res_d;

  // Scale: reciprocal estimate is exact or one short; one compare fixes it
  assign prod1 = PROD1_W'(x_q) * PROD1_W'(SCALE_RECIP);
  assign back1 = X_W'(qe_q) * X_W'(SCALE_DIV);
  assign rem1  = x_q - back1;
  assign v_d   = qe_q + SCALED_W'(rem1 >= X_W'(SCALE_DIV));

  // Sorted insertion: unfilled slots count as larger than any sample
  always_comb begin
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      gt[i] = (CNT_W'(i) >= count_q) || (win_q[i] > v_q);
    end
    win_d[0] = gt[0] ? v_q : win_q[0];
    for (int i = 1; i < WINDOW_SIZE; i++) begin
      if (!gt[i]) begin
        win_d[i] = win_q[i];
      end else if (gt[i-1]) begin
        win_d[i] = win_q[i-1];
      end else begin
        win_d[i] = v_q;
      end
    end
  end

  assign stat_o.last_sample = (count_q == CNT_W'(WINDOW_SIZE - 1));
  assign stat_o.sum_last    = (idx_q == IDX_W'(WINDOW_SIZE - TRIM_EACH_END - 1));

  // Reading: divide 2048*S by 100*M, then drop the offset
  assign u        = {acc_q, {U_SHIFT{1'b0}}};
  assign prod2    = PROD2_W'(u) * PROD2_W'(DIV_RECIP);
  assign back2    = U_W'(qd_q) * U_W'(DIV_D);
  assign rem2     = u - back2;
  assign qf       = {1'b0, qd_q} + (QD_W + 1)'(rem2 >= U_W'(DIV_D));
  assign res_full = $signed({1'b0, qf}) - $signed(RES_W'(READ_OFFSET));

  always_comb begin
    // qf is never negative, so only the top can overflow
    if (!MID_OK) begin
      res_d = '0;
    end else if (res_full > $signed(RES_W'(OUT_MAX))) begin
      res_d = OUT_W'(OUT_MAX);
    end else begin
      res_d = res_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= X_W'(raw_sample_i) * X_W'(SCALE_MUL);
    end
    if (cmd_i.est) begin
      qe_q <= prod1[SCALE_SHIFT +: SCALED_W];
    end
    if (cmd_i.fix) begin
      v_q <= v_d;
    end
    if (cmd_i.ins) begin
      win_q <= win_d;
    end
    if (cmd_i.sum_init) begin
      acc_q <= '0;
      idx_q <= IDX_W'(TRIM_EACH_END);
    end else if (cmd_i.sum_add) begin
      acc_q <= acc_q + SUM_W'(win_q[idx_q]);
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.div1) begin
      qd_q <= prod2[DIV_P +: QD_W];
    end
    if (cmd_i.div2) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.div2;
      if (cmd_i.div2) begin
        count_q <= '0;
      end else if (cmd_i.ins) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign valid_o      = valid_q;
  assign uv_average_o = res_q;

endmodule

// File: src/tmuf_checker.sv
module tmuf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              valid_o,
  input logic signed [tmuf_pkg::OUT_W-1:0] uv_average_o
);
  import tmuf_pkg::*;

  // A transfer always starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after a sample transfer");

  // A reading comes only at the end of a stretch of work
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy) && !busy)
    else $error("reading shown outside the end of work");

  // Readings are single-cycle strobes
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("reading strobe held longer than one cycle");

  // No reading right after a transfer
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !valid_o)
    else $error("reading shown right after a sample transfer");

  // Reading stays within the range the scaling allows
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($signed(uv_average_o) >= -17'sd2048) &&
                ($signed(uv_average_o) <= 17'sd36577))
    else $error("reading out of range");

endmodule

bind trimmed_mean_uv_sensor_filter tmuf_checker u_tmuf_checker (.*);
